// ===== hw/rtl/earb_pkg.sv =====
// Shared constants, types and elaboration-time tables of the edge-aware recursive blur.
package earb_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;
  localparam int unsigned ITERATIONS_DEF = 3;

  // Fixed widths of the pixel fields.
  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CHAN_W   = 32;
  localparam int unsigned PIX_W    = CHANNELS * CHAN_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SSIGMA = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSIGMA = 8'd3;

  // Arithmetic unit sizes.
  localparam int unsigned EXP_BITS = 20;
  localparam int unsigned DIV_NW   = 64;
  localparam int unsigned DIV_DW   = 32;
  localparam int unsigned KQ_W     = 22;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LINE_START,
    ST_LINK_RD,
    ST_GRAD,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_MUL2,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_EXP_MUL,
    ST_EXP_ACC,
    ST_COEF,
    ST_BLEND_MUL,
    ST_BLEND_ACC,
    ST_WRITE,
    ST_ADV,
    ST_LINE_NEXT,
    ST_FETCH_RD,
    ST_FETCH_OUT
  } earb_state_e;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } earb_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } earb_div_rsp_t;

  // Shift-subtract division, used only while building constants.
  function automatic logic [63:0] earb_udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Integer square root, used only while building constants.
  function automatic logic [63:0] earb_isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    v = v_in;
    r = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return r;
  endfunction

  // Q0.32 factor exp(-2^(b-16)): Taylor series up to b = 16, squaring above.
  function automatic logic [31:0] earb_exp_entry(input int b);
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic               stop;
    int                 bb;
    bb = (b > 16) ? 16 : b;
    sum = 64'sd1 <<< 32;
    term = 64'd1 << 32;
    stop = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!stop) begin
        term = earb_udiv64(term >> (16 - bb), 64'(k));
        if (term == 64'd0) stop = 1'b1;
        else if ((k & 1) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
    end
    term = $unsigned(sum);
    for (int j = 17; j <= b; j++) begin
      term = (term * term + (64'd1 << 31)) >> 32;
    end
    return term[31:0];
  endfunction

  localparam logic [31:0] EXP_TAB [EXP_BITS] = '{
    earb_exp_entry(0),  earb_exp_entry(1),  earb_exp_entry(2),  earb_exp_entry(3),
    earb_exp_entry(4),  earb_exp_entry(5),  earb_exp_entry(6),  earb_exp_entry(7),
    earb_exp_entry(8),  earb_exp_entry(9),  earb_exp_entry(10), earb_exp_entry(11),
    earb_exp_entry(12), earb_exp_entry(13), earb_exp_entry(14), earb_exp_entry(15),
    earb_exp_entry(16), earb_exp_entry(17), earb_exp_entry(18), earb_exp_entry(19)
  };

endpackage

// ===== hw/rtl/earb_div.sv =====
// Radix-2 restoring divider shared by both divisions of a link.
module earb_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  earb_pkg::earb_div_req_t req_i,
  output earb_pkg::earb_div_rsp_t rsp_o
);
  import earb_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  // One quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      quo_q <= req_i.num;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DW-1:0];
      quo_q <= {quo_q[DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== hw/rtl/edge_aware_recursive_blur.sv =====
// Top level of the edge-aware recursive blur: region stores, link sequencer, shared datapath.
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_ready_o  op, chan0..chan3, guide_value
//   out      output     out_valid_o / out_ready_i res0..res3, final_pixel
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load beat is written to the stores as it is accepted; a fetch beat holds off the input
// until its result is registered, once the output is free. The first fetch after a full load
// runs the filter if both sigmas are nonzero: ITERATIONS*2*(H*(W-1) + W*(H-1)) links, each with
// two 64-step divisions and up to twenty exponent passes through the shared multiplier.
// Reset is asynchronous and active low; the stores hold no reset value. Input and register
// writes wait while the sequencer is busy; a waiting result stalls only the next fetch.
module edge_aware_recursive_blur #(
  parameter int unsigned MAX_WIDTH  = earb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = earb_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned ITERATIONS = earb_pkg::ITERATIONS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic signed [earb_pkg::CHAN_W-1:0] chan0_i,
  input  logic signed [earb_pkg::CHAN_W-1:0] chan1_i,
  input  logic signed [earb_pkg::CHAN_W-1:0] chan2_i,
  input  logic signed [earb_pkg::CHAN_W-1:0] chan3_i,
  input  logic signed [earb_pkg::CHAN_W-1:0] guide_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [earb_pkg::CHAN_W-1:0] res0_o,
  output logic signed [earb_pkg::CHAN_W-1:0] res1_o,
  output logic signed [earb_pkg::CHAN_W-1:0] res2_o,
  output logic signed [earb_pkg::CHAN_W-1:0] res3_o,
  output logic                               final_pixel_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [earb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [earb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import earb_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADW   = $clog2(DEPTH);
  localparam int unsigned CNW   = $clog2(DEPTH + 1);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned LW    = $clog2(MAXD + 1);
  localparam int unsigned ITW   = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
  localparam logic [63:0] KM    = (2 * ((64'd1 << (2 * ITERATIONS)) - 64'd1)) / 3;
  localparam logic [KQ_W-1:0] KQ = KQ_W'(earb_isqrt64(KM << 32));
  localparam int unsigned BW    = $clog2(EXP_BITS);

  // Configuration registers.
  logic [6:0]  width_q;
  logic [6:0]  height_q;
  logic [15:0] ssig_q;
  logic [23:0] rsig_q;

  // Control state.
  earb_state_e     state_q, state_d;
  logic [CNW-1:0]  load_cnt_q;
  logic [CNW-1:0]  fetch_cnt_q;
  logic            filtered_q;
  logic            out_valid_q;
  logic [ITW-1:0]  iter_q;
  logic            col_q;
  logic            bwd_q;
  logic [LW-1:0]   line_q;
  logic [LW-1:0]   pos_q;
  logic [ADW-1:0]  base_q;
  logic [ADW-1:0]  idx_q;
  logic [BW-1:0]   bit_q;
  logic [1:0]      chan_q;

  // Datapath registers.
  logic [PIX_W-1:0]    pix_a_q;
  logic [PIX_W-1:0]    pix_b_q;
  logic [CHAN_W-1:0]   gd_a_q;
  logic [CHAN_W-1:0]   gd_b_q;
  logic signed [67:0]  prod_q;
  logic [31:0]         step_q;
  logic [EXP_BITS-1:0] x_q;
  logic                x_big_q;
  logic [32:0]         acc_q;
  logic [15:0]         a_q;
  logic [PIX_W-1:0]    newpix_q;
  logic [PIX_W-1:0]    out_pix_q;
  logic                out_final_q;

  // Region stores.
  logic [PIX_W-1:0]  pix_mem [DEPTH];
  logic [CHAN_W-1:0] gd_mem  [DEPTH];

  // Clamped region size and derived line geometry.
  logic [WW-1:0]  w_use;
  logic [HW-1:0]  h_use;
  logic [CNW-1:0] area;
  logic [LW-1:0]  len;
  logic [LW-1:0]  lines;
  logic [ADW-1:0] stride;
  logic [ADW-1:0] lstep;
  logic [ADW-1:0] nb_idx;

  always_comb begin
    if (width_q == 7'd0) w_use = WW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) w_use = WW'(MAX_WIDTH);
    else w_use = WW'(width_q);
    if (height_q == 7'd0) h_use = HW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_use = HW'(MAX_HEIGHT);
    else h_use = HW'(height_q);
  end

  assign area   = CNW'(32'(w_use) * 32'(h_use));
  assign len    = col_q ? LW'(h_use) : LW'(w_use);
  assign lines  = col_q ? LW'(w_use) : LW'(h_use);
  assign stride = col_q ? ADW'(w_use) : ADW'(1);
  assign lstep  = col_q ? ADW'(1) : ADW'(w_use);
  assign nb_idx = bwd_q ? idx_q + stride : idx_q - stride;

  // Handshakes.
  logic in_acc;
  logic cfg_acc;
  logic out_free;
  logic load_ok;
  logic run_filter;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign load_ok     = load_cnt_q < area;
  assign run_filter  = !filtered_q && (ssig_q != 16'd0) && (rsig_q != 24'd0);

  // Guide gradient of the current link.
  logic signed [32:0] gdiff;
  logic [32:0]        dg;
  assign gdiff = $signed({gd_a_q[31], gd_a_q}) - $signed({gd_b_q[31], gd_b_q});
  assign dg    = gdiff[32] ? $unsigned(-gdiff) : $unsigned(gdiff);

  // Channel difference for the blend.
  logic signed [31:0] v_ch;
  logic signed [31:0] n_ch;
  logic signed [32:0] cdiff;
  assign v_ch  = pix_a_q[32*chan_q +: 32];
  assign n_ch  = pix_b_q[32*chan_q +: 32];
  assign cdiff = $signed({n_ch[31], n_ch}) - $signed({v_ch[31], v_ch});

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod_d;
  logic               mul_en;
  assign prod_d = mul_a * mul_b;

  // Shared divider.
  earb_div_req_t div_req;
  earb_div_rsp_t div_rsp;
  logic [5:0]    kshift;
  assign kshift = 6'(ITERATIONS - 1) - 6'(iter_q) + 6'd8;

  earb_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Derived link values.
  logic [31:0]        step_d;
  logic [33:0]        acc_rnd;
  logic [63:0]        exp_rnd;
  logic signed [67:0] bl_sum;
  assign step_d  = (div_rsp.quo > 64'hFFFE_FFFF) ? 32'hFFFF_FFFF
                                                 : 32'(div_rsp.quo + 64'h1_0000);
  assign acc_rnd = {1'b0, acc_q} + 34'd32768;
  assign exp_rnd = (prod_q[63:0] + 64'h8000_0000) >> 32;
  assign bl_sum  = prod_q + 68'sd32768;

  // Next state and datapath steering.
  logic rd_en;
  logic [ADW-1:0] rd_addr_a;

  always_comb begin
    state_d     = state_q;
    rd_en       = 1'b0;
    rd_addr_a   = idx_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op_i && !load_ok) begin
          state_d = run_filter ? ST_LINE_START : ST_FETCH_RD;
        end
      end
      ST_LINE_START: state_d = (len == LW'(1)) ? ST_LINE_NEXT : ST_LINK_RD;
      ST_LINK_RD: begin
        rd_en   = 1'b1;
        state_d = ST_GRAD;
      end
      ST_GRAD: begin
        mul_en  = 1'b1;
        mul_a   = $signed({18'd0, ssig_q});
        mul_b   = $signed({1'b0, dg});
        state_d = ST_DIV1_GO;
      end
      ST_DIV1_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {prod_q[55:0], 8'd0};
        div_req.den   = DIV_DW'(rsig_q);
        state_d       = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: if (div_rsp.done) state_d = ST_MUL2;
      ST_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = $signed(34'(KQ));
        mul_b   = $signed({2'd0, step_q});
        state_d = ST_DIV2_GO;
      end
      ST_DIV2_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q[63:0];
        div_req.den   = DIV_DW'({16'd0, ssig_q}) << kshift;
        state_d       = ST_DIV2_WAIT;
      end
      ST_DIV2_WAIT: if (div_rsp.done) state_d = ST_EXP_MUL;
      ST_EXP_MUL: begin
        if (x_big_q) begin
          state_d = ST_COEF;
        end else if (x_q[bit_q]) begin
          mul_en  = 1'b1;
          mul_a   = $signed({1'b0, acc_q});
          mul_b   = $signed({2'd0, EXP_TAB[bit_q]});
          state_d = ST_EXP_ACC;
        end else if (bit_q == BW'(EXP_BITS - 1)) begin
          state_d = ST_COEF;
        end
      end
      ST_EXP_ACC: state_d = (bit_q == BW'(EXP_BITS - 1)) ? ST_COEF : ST_EXP_MUL;
      ST_COEF: state_d = ST_BLEND_MUL;
      ST_BLEND_MUL: begin
        mul_en  = 1'b1;
        mul_a   = $signed({18'd0, a_q});
        mul_b   = $signed({cdiff[32], cdiff});
        state_d = ST_BLEND_ACC;
      end
      ST_BLEND_ACC: state_d = (chan_q == 2'd3) ? ST_WRITE : ST_BLEND_MUL;
      ST_WRITE: state_d = ST_ADV;
      ST_ADV: begin
        if (bwd_q && pos_q == '0) state_d = ST_LINE_NEXT;
        else state_d = ST_LINK_RD;
      end
      ST_LINE_NEXT: begin
        if (line_q == lines - 1'b1 && col_q && iter_q == ITW'(ITERATIONS - 1)) begin
          state_d = ST_FETCH_RD;
        end else begin
          state_d = ST_LINE_START;
        end
      end
      ST_FETCH_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = fetch_cnt_q[ADW-1:0];
        state_d   = ST_FETCH_OUT;
      end
      ST_FETCH_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // Counters, sequencer position and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 7'd64;
      height_q    <= 7'd64;
      ssig_q      <= '0;
      rsig_q      <= '0;
      load_cnt_q  <= '0;
      fetch_cnt_q <= '0;
      filtered_q  <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      col_q       <= 1'b0;
      bwd_q       <= 1'b0;
      line_q      <= '0;
      pos_q       <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      chan_q      <= '0;
    end else begin
      // Output beat: set when a fetch completes, cleared when taken.
      if (state_q == ST_FETCH_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !op_i && load_ok) load_cnt_q <= load_cnt_q + 1'b1;
          if (in_acc && op_i && !load_ok) begin
            iter_q <= '0;
            col_q  <= 1'b0;
            bwd_q  <= 1'b0;
            line_q <= '0;
            base_q <= '0;
            if (!run_filter) filtered_q <= 1'b1;
          end
        end
        ST_LINE_START: begin
          bwd_q <= 1'b0;
          pos_q <= LW'(1);
          idx_q <= base_q + stride;
        end
        ST_DIV2_WAIT: bit_q <= '0;
        ST_EXP_MUL: begin
          if (!x_big_q && !x_q[bit_q] && bit_q != BW'(EXP_BITS - 1)) bit_q <= bit_q + 1'b1;
        end
        ST_EXP_ACC: if (bit_q != BW'(EXP_BITS - 1)) bit_q <= bit_q + 1'b1;
        ST_COEF: chan_q <= '0;
        ST_BLEND_ACC: chan_q <= chan_q + 1'b1;
        ST_ADV: begin
          if (!bwd_q) begin
            if (pos_q == len - 1'b1) begin
              bwd_q <= 1'b1;
              pos_q <= len - LW'(2);
              idx_q <= idx_q - stride;
            end else begin
              pos_q <= pos_q + 1'b1;
              idx_q <= idx_q + stride;
            end
          end else if (pos_q != '0) begin
            pos_q <= pos_q - 1'b1;
            idx_q <= idx_q - stride;
          end
        end
        ST_LINE_NEXT: begin
          bwd_q <= 1'b0;
          if (line_q == lines - 1'b1) begin
            line_q <= '0;
            base_q <= '0;
            if (!col_q) begin
              col_q <= 1'b1;
            end else if (iter_q == ITW'(ITERATIONS - 1)) begin
              filtered_q <= 1'b1;
            end else begin
              iter_q <= iter_q + 1'b1;
              col_q  <= 1'b0;
            end
          end else begin
            line_q <= line_q + 1'b1;
            base_q <= base_q + lstep;
          end
        end
        ST_FETCH_OUT: begin
          if (out_free) begin
            if (fetch_cnt_q + 1'b1 >= area) begin
              fetch_cnt_q <= '0;
              load_cnt_q  <= '0;
              filtered_q  <= 1'b0;
            end else begin
              fetch_cnt_q <= fetch_cnt_q + 1'b1;
            end
          end
        end
        default: ;
      endcase

      // A register write abandons the region in progress.
      if (cfg_acc && cfg_index_i <= CFG_RSIGMA) begin
        load_cnt_q  <= '0;
        fetch_cnt_q <= '0;
        filtered_q  <= 1'b0;
        unique case (cfg_index_i[1:0])
          CFG_WIDTH[1:0]:  width_q  <= cfg_data_i[6:0];
          CFG_HEIGHT[1:0]: height_q <= cfg_data_i[6:0];
          CFG_SSIGMA[1:0]: ssig_q   <= cfg_data_i[15:0];
          CFG_RSIGMA[1:0]: rsig_q   <= cfg_data_i[23:0];
          default: ;
        endcase
      end
    end
  end

  // Store writes: loads from the input, blended pixels from the sequencer.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && !op_i && load_ok) begin
      pix_mem[load_cnt_q[ADW-1:0]] <= {chan3_i, chan2_i, chan1_i, chan0_i};
      gd_mem[load_cnt_q[ADW-1:0]]  <= guide_value_i;
    end else if (state_q == ST_WRITE) begin
      pix_mem[idx_q] <= newpix_q;
    end
  end

  // Store reads: the pixel being updated or fetched and its neighbor.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pix_a_q <= pix_mem[rd_addr_a];
      pix_b_q <= pix_mem[nb_idx];
      gd_a_q  <= gd_mem[rd_addr_a];
      gd_b_q  <= gd_mem[nb_idx];
    end
  end

  // Link arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= prod_d;
    if (state_q == ST_DIV1_WAIT && div_rsp.done) step_q <= step_d;
    if (state_q == ST_DIV2_WAIT && div_rsp.done) begin
      x_q     <= div_rsp.quo[EXP_BITS-1:0];
      x_big_q <= |div_rsp.quo[DIV_NW-1:EXP_BITS];
      acc_q   <= 33'h1_0000_0000;
    end
    if (state_q == ST_EXP_ACC) acc_q <= exp_rnd[32:0];
    if (state_q == ST_COEF) begin
      if (x_big_q) a_q <= '0;
      else if (acc_rnd[33:16] > 18'd65535) a_q <= 16'hFFFF;
      else a_q <= acc_rnd[31:16];
    end
    if (state_q == ST_BLEND_ACC) newpix_q[32*chan_q +: 32] <= v_ch + bl_sum[47:16];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH_OUT && out_free) begin
      out_pix_q   <= pix_a_q;
      out_final_q <= (fetch_cnt_q == area - 1'b1);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign res0_o        = out_pix_q[31:0];
  assign res1_o        = out_pix_q[63:32];
  assign res2_o        = out_pix_q[95:64];
  assign res3_o        = out_pix_q[127:96];
  assign final_pixel_o = out_final_q;

endmodule
